>>> design/sus_pkg.sv
// Package for the sorted unique set: status codes, sequencer states and the
// per-cell control bundle. No dependencies.
package sus_pkg;

  typedef enum logic [2:0] {
    ST_INSERTED  = 3'd0,
    ST_PRESENT   = 3'd1,
    ST_REMOVED   = 3'd2,
    ST_NOT_FOUND = 3'd3,
    ST_FULL      = 3'd4
  } status_e;

  typedef enum logic {
    MODE_INSERT = 1'b0,
    MODE_DELETE = 1'b1
  } mode_e;

  typedef enum logic {
    S_IDLE  = 1'b0,
    S_APPLY = 1'b1
  } state_e;

  // Control broadcast to every cell of the row.
  typedef struct packed {
    logic sample;  // latch compare flags against the incoming item
    logic ins;     // open a slot at the insert point and shift toward the tail
    logic del;     // close the slot of the hit and shift toward the head
  } cell_ctl_t;

endpackage

>>> design/sus_cell.sv
// One cell of the sorted row: holds a single value and its compare flags.
// Depends on sus_pkg.
module sus_cell #(
  parameter int VALUE_WIDTH = 32
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  sus_pkg::cell_ctl_t            ctl_i,
  input  logic                          live_i,
  input  logic                          dir_i,
  input  logic signed [VALUE_WIDTH-1:0] key_i,
  input  logic                          left_before_i,
  input  logic signed [VALUE_WIDTH-1:0] left_value_i,
  input  logic signed [VALUE_WIDTH-1:0] right_value_i,
  output logic                          before_o,
  output logic                          eq_o,
  output logic signed [VALUE_WIDTH-1:0] value_o
);
  import sus_pkg::*;

  logic                          before_q, before_d;
  logic                          eq_q, eq_d;
  logic signed [VALUE_WIDTH-1:0] value_q, value_d;

  always_comb begin
    before_d = before_q;
    eq_d     = eq_q;
    if (ctl_i.sample) begin
      // dir_i high: larger values sit nearer the head of the row
      before_d = live_i && (dir_i ? (value_q > key_i) : (value_q < key_i));
      eq_d     = live_i && (value_q == key_i);
    end
  end

  always_comb begin
    value_d = value_q;
    if (ctl_i.ins && !before_q) begin
      value_d = left_before_i ? key_i : left_value_i;
    end else if (ctl_i.del && !before_q) begin
      value_d = right_value_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      before_q <= 1'b0;
      eq_q     <= 1'b0;
    end else begin
      before_q <= before_d;
      eq_q     <= eq_d;
    end
  end

  always_ff @(posedge clk_i) begin
    value_q <= value_d;
  end

  assign before_o = before_q;
  assign eq_o     = eq_q;
  assign value_o  = value_q;

endmodule

>>> design/sorted_unique_set.sv
// Top level of the sorted unique set: a row of compare-and-shift cells with
// a two-state sequencer. Depends on sus_pkg and sus_cell.
//
//  channel | direction | handshake                 | payload
//  --------+-----------+---------------------------+---------------------------
//  in      | to block  | in_valid_i / in_stall_o   | mode_i, value_i
//  out     | from block| out_valid_o / out_stall_i | status_o, entry_count_o
//  cfg     | to block  | cfg_valid_i / cfg_ready_o | sort_order_i
//
// In the accept cycle every cell compares its value against the item and
// latches the result; in the apply state the row shifts by one place on an
// insert or a removal, and the result is written to the output register.
// The apply state holds while the output register still holds an untaken
// item.
// Reset clears the count and selects descending order; cell contents need
// no clearing since only the first entry_count cells are ever compared.
// A change of sort order flips the row's reading direction.
module sorted_unique_set #(
  parameter int CAPACITY    = 16,
  parameter int VALUE_WIDTH = 32
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic                          mode_i,
  input  logic signed [VALUE_WIDTH-1:0] value_i,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic                          sort_order_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [2:0]                    status_o,
  output logic [4:0]                    entry_count_o
);
  import sus_pkg::*;

  localparam int CW = $clog2(CAPACITY + 1);

  state_e                        state_q, state_d;
  logic [CW-1:0]                 count_q, count_d;
  logic                          order_q;
  logic                          rev_q;       // row is stored against sort_order
  logic                          mode_q;
  logic signed [VALUE_WIDTH-1:0] value_q;
  logic                          out_valid_q;
  status_e                       status_q, status_d;
  logic [4:0]                    entry_q;

  logic                          accept;
  logic                          cfg_write;
  logic                          apply_go;
  logic                          hit;
  logic                          full;
  logic                          ins_go, del_go;
  cell_ctl_t                     ctl;
  logic signed [VALUE_WIDTH-1:0] key;
  logic [CW+4:0]                 count_ext;

  logic [CAPACITY-1:0]           before_vec;
  logic [CAPACITY-1:0]           eq_vec;
  logic signed [VALUE_WIDTH-1:0] val_arr [CAPACITY];

  assign accept    = in_valid_i && !in_stall_o;
  assign cfg_write = cfg_valid_i && cfg_ready_o;
  assign in_stall_o  = (state_q != S_IDLE);
  assign cfg_ready_o = (state_q == S_IDLE);

  // Compare against the live input while accepting, against the held item after.
  assign key  = (state_q == S_IDLE) ? value_i : value_q;
  assign hit  = |eq_vec;
  assign full = (count_q >= CW'(CAPACITY));

  // Row of cells; the head is cell 0.
  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    logic                          left_before;
    logic signed [VALUE_WIDTH-1:0] left_value;
    logic signed [VALUE_WIDTH-1:0] right_value;

    if (g == 0) begin : g_head
      assign left_before = 1'b1;
      assign left_value  = key;
    end else begin : g_body
      assign left_before = before_vec[g-1];
      assign left_value  = val_arr[g-1];
    end

    if (g == CAPACITY - 1) begin : g_tail
      assign right_value = val_arr[g];
    end else begin : g_inner
      assign right_value = val_arr[g+1];
    end

    sus_cell #(
      .VALUE_WIDTH(VALUE_WIDTH)
    ) u_cell (
      .clk_i         (clk_i),
      .rst_ni        (rst_ni),
      .ctl_i         (ctl),
      .live_i        (count_q > CW'(g)),
      .dir_i         (order_q ^ rev_q),
      .key_i         (key),
      .left_before_i (left_before),
      .left_value_i  (left_value),
      .right_value_i (right_value),
      .before_o      (before_vec[g]),
      .eq_o          (eq_vec[g]),
      .value_o       (val_arr[g])
    );
  end

  // Sequencer: next state, row control and result.
  always_comb begin
    state_d  = state_q;
    count_d  = count_q;
    status_d = status_q;
    apply_go = 1'b0;
    ins_go   = 1'b0;
    del_go   = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          state_d = S_APPLY;
        end
      end
      S_APPLY: begin
        // hold while the previous result has not been taken
        if (!(out_valid_q && out_stall_i)) begin
          apply_go = 1'b1;
          state_d  = S_IDLE;
          if (mode_q == MODE_INSERT) begin
            if (hit) begin
              status_d = ST_PRESENT;
            end else if (full) begin
              status_d = ST_FULL;
            end else begin
              ins_go   = 1'b1;
              count_d  = count_q + 1'b1;
              status_d = ST_INSERTED;
            end
          end else begin
            if (hit) begin
              del_go   = 1'b1;
              count_d  = count_q - 1'b1;
              status_d = ST_REMOVED;
            end else begin
              status_d = ST_NOT_FOUND;
            end
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    ctl.sample = accept;
    ctl.ins    = ins_go;
    ctl.del    = del_go;
  end

  // Report the count modulo 32.
  assign count_ext = {5'd0, count_d};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      order_q     <= 1'b1;
      rev_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      if (cfg_write && (sort_order_i != order_q)) begin
        // flip the reading direction instead of moving entries
        order_q <= sort_order_i;
        rev_q   <= ~rev_q;
      end
      if (apply_go) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      mode_q  <= mode_i;
      value_q <= value_i;
    end
    if (apply_go) begin
      status_q <= status_d;
      entry_q  <= count_ext[4:0];
    end
  end

  assign out_valid_o   = out_valid_q;
  assign status_o      = status_q;
  assign entry_count_o = entry_q;

  // The count never exceeds the row length.
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(CAPACITY))
    else $error("entry count beyond capacity");

  // Entries are unique: at most one live cell can match the item.
  a_unique_hit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_APPLY) |-> $onehot0(eq_vec))
    else $error("more than one cell matched");

  // The row is sorted: the cells ahead of the item form a prefix.
  a_prefix: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_APPLY) |-> $onehot({1'b0, before_vec} + 1'b1))
    else $error("compare flags do not form a prefix");

  // An insert grows the count by exactly one.
  a_ins_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ins_go |=> (count_q == $past(count_q) + 1'b1))
    else $error("insert did not grow the count");

  // A result appears only out of an apply cycle.
  a_out_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(apply_go))
    else $error("result without apply cycle");

endmodule

>>> verif/sorted_unique_set_tb.sv
// Self-checking testbench for sorted_unique_set: directed and random insert and
// delete items under both sort orders, with random idling on both channels.
// Depends on sus_pkg and the sorted_unique_set RTL.
module sorted_unique_set_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import sus_pkg::*;

  localparam int CAPACITY    = 16;
  localparam int VALUE_WIDTH = 32;
  localparam int PHASES      = 8;
  localparam int PHASE_ITEMS = 235;
  localparam int POOL        = 24;
  localparam int LIMIT       = 400000;
  localparam int JAM_AT      = 400;  // accepted items before the long hold-off
  localparam int JAM_CYCLES  = 60;

  typedef struct packed {
    mode_e                         mode;
    logic signed [VALUE_WIDTH-1:0] value;
  } set_op_t;

  typedef struct packed {
    status_e    status;
    logic [4:0] count;
  } outcome_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  // Every block input starts at a known value.
  logic                          in_valid_i = 1'b0;
  logic                          mode_i = 1'b0;
  logic signed [VALUE_WIDTH-1:0] value_i = '0;
  logic                          cfg_valid_i = 1'b0;
  logic                          sort_order_i = 1'b1;
  logic                          out_stall_i = 1'b0;
  logic                          in_stall_o;
  logic                          cfg_ready_o;
  logic                          out_valid_o;
  logic [2:0]                    status_o;
  logic [4:0]                    entry_count_o;

  // Items waiting for the driver, and results still owed by the block.
  set_op_t  ops_to_send[$];
  outcome_t predicted_outcomes[$];

  // Shadow of the set: values in the current order, plus that order.
  logic signed [VALUE_WIDTH-1:0] held_values[$];
  logic                          descending = 1'b1;

  int   ops_queued = 0;
  int   ops_accepted = 0;
  int   results_seen = 0;
  int   mismatches = 0;
  int   order_writes = 0;
  int   status_tally[5] = '{default: 0};
  int   cycle_count = 0;
  logic calm = 1'b0;  // no idling on either side once set
  int   gap_left;
  int   stall_left;
  int   jam_left;
  logic jam_done;
  outcome_t oldest;

  sorted_unique_set #(
    .CAPACITY   (CAPACITY),
    .VALUE_WIDTH(VALUE_WIDTH)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .mode_i       (mode_i),
    .value_i      (value_i),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .sort_order_i (sort_order_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .status_o     (status_o),
    .entry_count_o(entry_count_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Apply one insert or delete to the shadow set and return what the block
  // must report for it.
  function automatic outcome_t update_set(mode_e op_mode, logic signed [VALUE_WIDTH-1:0] v);
    int       pos;
    logic     hit;
    outcome_t res;
    pos = 0;
    // Walk past every entry that sorts ahead of v in the current order.
    while (pos < held_values.size() &&
           (descending ? held_values[pos] > v : held_values[pos] < v))
      pos++;
    hit = (pos < held_values.size()) && (held_values[pos] == v);
    if (op_mode == MODE_INSERT) begin
      if (hit) begin
        res.status = ST_PRESENT;  // a duplicate wins over a full set
      end else if (held_values.size() >= CAPACITY) begin
        res.status = ST_FULL;
      end else begin
        held_values.insert(pos, v);
        res.status = ST_INSERTED;
      end
    end else begin
      if (hit) begin
        held_values.delete(pos);
        res.status = ST_REMOVED;
      end else begin
        res.status = ST_NOT_FOUND;
      end
    end
    res.count = 5'(held_values.size());  // reported modulo 32
    return res;
  endfunction

  // A new order flips the held entries; writing the current order is a no-op.
  function automatic void change_order(logic new_order);
    logic signed [VALUE_WIDTH-1:0] flipped[$];
    if (new_order == descending) return;
    descending = new_order;
    foreach (held_values[i]) flipped.push_front(held_values[i]);
    held_values = flipped;
  endfunction

  // Driver: offer queued items, with random gaps. Hold valid and payload
  // steady while the block stalls.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      gap_left   <= 0;
    end else if (!in_valid_i || !in_stall_o) begin
      if (gap_left != 0) begin
        in_valid_i <= 1'b0;
        gap_left   <= gap_left - 1;
      end else if (ops_to_send.size() == 0) begin
        in_valid_i <= 1'b0;
      end else if (!calm && $urandom_range(0, 7) == 0) begin
        // Start an idle burst.
        in_valid_i <= 1'b0;
        gap_left   <= $urandom_range(0, 9);
      end else begin
        in_valid_i <= 1'b1;
        mode_i     <= ops_to_send[0].mode;
        value_i    <= ops_to_send[0].value;
        void'(ops_to_send.pop_front());
      end
    end
  end

  // Long hold-off on the result side, counted here, so that the block backs
  // up and stalls its input while the driver keeps offering.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      jam_left <= 0;
      jam_done <= 1'b0;
    end else if (!jam_done && ops_accepted >= JAM_AT) begin
      jam_left <= JAM_CYCLES;
      jam_done <= 1'b1;
    end else if (jam_left != 0) begin
      jam_left <= jam_left - 1;
    end
  end

  // Monitor: drive the result stall, check each taken result against the
  // oldest prediction, then track config writes and accepted items.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      stall_left  <= 0;
      held_values.delete();
      descending = 1'b1;
    end else begin
      if (jam_left != 0) begin
        out_stall_i <= 1'b1;
      end else if (stall_left != 0) begin
        out_stall_i <= 1'b1;
        stall_left  <= stall_left - 1;
      end else if (!calm && $urandom_range(0, 7) == 0) begin
        out_stall_i <= 1'b1;
        stall_left  <= $urandom_range(0, 9);
      end else begin
        out_stall_i <= 1'b0;
      end

      if (out_valid_o && !out_stall_i) begin
        results_seen++;
        if (status_o < 5) status_tally[status_o]++;
        if (predicted_outcomes.size() == 0) begin
          $error("status: expected no result, got %0d (count %0d)", status_o, entry_count_o);
          mismatches++;
        end else begin
          oldest = predicted_outcomes.pop_front();
          if (status_o !== oldest.status) begin
            $error("status: expected %0d, got %0d", oldest.status, status_o);
            mismatches++;
          end
          if (entry_count_o !== oldest.count) begin
            $error("entry_count: expected %0d, got %0d", oldest.count, entry_count_o);
            mismatches++;
          end
        end
      end

      if (cfg_valid_i && cfg_ready_o) begin
        change_order(sort_order_i);
        order_writes++;
      end

      if (in_valid_i && !in_stall_o) begin
        predicted_outcomes.push_back(update_set(mode_e'(mode_i), value_i));
        ops_accepted++;
      end
    end
  end

  // Watchdog: end a hung run.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("end of test: mismatches");
      $finish;
    end
  end

  task automatic queue_op(mode_e op_mode, logic signed [VALUE_WIDTH-1:0] v);
    set_op_t op;
    op.mode  = op_mode;
    op.value = v;
    ops_to_send.push_back(op);
    ops_queued++;
  endtask

  // Wait until every queued item is in and every result is out, then let
  // the pipeline go quiet.
  task automatic settle();
    while (ops_accepted != ops_queued || predicted_outcomes.size() != 0)
      @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_order(logic new_order);
    @(posedge clk_i);
    cfg_valid_i  <= 1'b1;
    sort_order_i <= new_order;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
  endtask

  initial begin
    logic signed [VALUE_WIDTH-1:0] value_pool[POOL];
    logic signed [VALUE_WIDTH-1:0] snapshot[$];
    logic signed [VALUE_WIDTH-1:0] pick;
    logic                          fill;
    mode_e                         op_mode;
    int                            roll;

    // Extremes first, then random values shared by the whole run so that
    // inserts and deletes keep hitting one another.
    value_pool[0] = 32'h8000_0000;
    value_pool[1] = 32'h7fff_ffff;
    value_pool[2] = 32'h0000_0000;
    value_pool[3] = 32'hffff_ffff;
    value_pool[4] = 32'h0000_0001;
    for (int i = 5; i < POOL; i++) value_pool[i] = $urandom;

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Same order as after reset: nothing moves.
    write_order(1'b1);

    // Directed: empty set, last value removed and re-added, duplicates,
    // value extremes, a full set refusing a new value but not a duplicate.
    queue_op(MODE_DELETE, 32'sd7);
    queue_op(MODE_INSERT, 32'sd7);
    queue_op(MODE_DELETE, 32'sd7);
    queue_op(MODE_INSERT, 32'sd7);
    queue_op(MODE_INSERT, 32'sd7);
    queue_op(MODE_INSERT, 32'h8000_0000);
    queue_op(MODE_INSERT, 32'h7fff_ffff);
    queue_op(MODE_INSERT, 32'sd0);
    queue_op(MODE_INSERT, -32'sd1);
    for (int i = 0; i < 11; i++) queue_op(MODE_INSERT, 32'sd100 + i);
    queue_op(MODE_INSERT, 32'sd200);
    queue_op(MODE_INSERT, 32'h8000_0000);
    queue_op(MODE_DELETE, 32'sd555);
    queue_op(MODE_DELETE, 32'h7fff_ffff);
    queue_op(MODE_INSERT, 32'sd1);
    settle();

    // Flip a full set to ascending, then write ascending again.
    write_order(1'b0);
    write_order(1'b0);

    // Random phases alternate between filling and draining the set, with
    // an order write between phases.
    for (int p = 0; p < PHASES; p++) begin
      snapshot = held_values;
      fill     = (p % 2 == 0);
      if (p == PHASES - 1) calm = 1'b1;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        op_mode = ($urandom_range(0, 99) < (fill ? 75 : 30)) ? MODE_INSERT : MODE_DELETE;
        roll    = $urandom_range(0, 9);
        if (roll < 2)
          pick = $urandom;
        else if (op_mode == MODE_DELETE && roll < 6 && snapshot.size() != 0)
          pick = snapshot[$urandom_range(0, snapshot.size() - 1)];
        else
          pick = value_pool[$urandom_range(0, POOL - 1)];
        queue_op(op_mode, pick);
      end
      settle();
      write_order((p < 2) ? p[0] : 1'($urandom_range(0, 1)));
    end

    settle();
    repeat (10) @(posedge clk_i);

    $display("covered %0d items, %0d results, %0d order writes, final count %0d",
             ops_accepted, results_seen, order_writes, held_values.size());
    $display("status mix: inserted %0d, present %0d, removed %0d, absent %0d, full %0d",
             status_tally[0], status_tally[1], status_tally[2], status_tally[3],
             status_tally[4]);
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
